[design/assert_macros.svh]
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/edc_pkg.sv]
// package: constants, register codes and control structs of the dip counter
`default_nettype none

package edc_pkg;

  localparam int HISTORY_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF   = 12;

  localparam int AVG_W      = 28;
  localparam int FRAC_W     = 16;
  localparam int DIP_W      = 10;
  localparam int LEN_W      = 11;
  localparam int THR_W      = 12;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIP_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REARM_MARGIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EMA_GAIN       = 2'd3;

  localparam logic [LEN_W-1:0]  HISTORY_LENGTH_RST = 11'd1000;
  localparam logic [THR_W-1:0]  DIP_THRESHOLD_RST  = 12'd228;
  localparam logic [THR_W-1:0]  REARM_MARGIN_RST   = 12'd68;
  localparam logic [GAIN_W-1:0] EMA_GAIN_RST       = 16'd66;

  typedef struct packed {
    logic write_hist;
    logic mul_en;
    logic upd_en;
    logic scan_setup;
    logic scan_en;
    logic out_load;
  } edc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } edc_status_t;

endpackage

`default_nettype wire

[design/edc_stream_if.sv]
// item channel interfaces: input items and result items
`default_nettype none

interface edc_in_if #(
  parameter int SAMPLE_BITS = edc_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface edc_out_if #(
  parameter int FILL_W = $clog2(edc_pkg::HISTORY_DEPTH_DEF + 1)
);
  logic                        valid;
  logic                        ready;
  logic [edc_pkg::AVG_W-1:0]   average;
  logic                        average_valid;
  logic [edc_pkg::DIP_W-1:0]   dip_count;
  logic [FILL_W-1:0]           history_fill;

  modport source (output valid, output average, output average_valid,
                  output dip_count, output history_fill, input ready);
  modport sink   (input valid, input average, input average_valid,
                  input dip_count, input history_fill, output ready);
endinterface

`default_nettype wire

[design/edc_ram.sv]
// generic single-port ram with registered read
`default_nettype none

module edc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[design/edc_ctrl.sv]
// controller state machine: sequences sample updates and history scans
`default_nettype none
`include "assert_macros.svh"

module edc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_opcode,
  output logic                      in_ready,
  output edc_pkg::edc_cmd_t         cmd,
  input  wire edc_pkg::edc_status_t status
);

  import edc_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    S_WRITE,
    S_MUL,
    S_UPD,
    Q_SETUP,
    Q_SCAN,
    FINISH
  } state_t;

  state_t state_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= IDLE;
    end else begin
      case (state_q)
        IDLE: begin
          if (in_valid) begin
            state_q <= (in_opcode == OP_QUERY) ? Q_SETUP : S_WRITE;
          end
        end
        S_WRITE: state_q <= S_MUL;
        S_MUL:   state_q <= S_UPD;
        S_UPD:   state_q <= FINISH;
        Q_SETUP: state_q <= Q_SCAN;
        Q_SCAN: begin
          if (status.scan_done) begin
            state_q <= FINISH;
          end
        end
        FINISH: begin
          if (!status.out_busy) begin
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    in_ready       = (state_q == IDLE);
    cmd.write_hist = (state_q == S_WRITE);
    cmd.mul_en     = (state_q == S_MUL);
    cmd.upd_en     = (state_q == S_UPD);
    cmd.scan_setup = (state_q == Q_SETUP);
    cmd.scan_en    = (state_q == Q_SCAN);
    cmd.out_load   = (state_q == FINISH) && !status.out_busy;
  end

  `ASSERT_NEXT(a_accept_dispatch, clk, rst, (state_q == IDLE) && in_valid, (state_q == S_WRITE) || (state_q == Q_SETUP), "item accepted but no work started")
  `ASSERT_NEXT(a_scan_finish, clk, rst, (state_q == Q_SCAN) && status.scan_done, state_q == FINISH, "scan finished without result")

endmodule

`default_nettype wire

[design/edc_datapath.sv]
// datapath: config registers, average update, history ram, dip scan, result register
`default_nettype none
`include "assert_macros.svh"

module edc_datapath #(
  parameter int HISTORY_DEPTH = edc_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = edc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [edc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [edc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_accept,
  input  wire logic                            in_opcode,
  input  wire logic [SAMPLE_BITS-1:0]          in_sample,
  input  wire edc_pkg::edc_cmd_t               cmd,
  output edc_pkg::edc_status_t                 status,
  edc_out_if.source                            result
);

  import edc_pkg::*;

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int NW     = ((FILL_W > LEN_W) ? FILL_W : LEN_W) + 1;
  localparam int SW     = SAMPLE_BITS + FRAC_W;
  localparam int DW     = ((SW > AVG_W) ? SW : AVG_W) + 1;
  localparam int MAG_W  = DW - 1;
  localparam int PROD_W = MAG_W + GAIN_W;
  localparam int NX_W   = MAG_W + 2;
  localparam int CW     = ((SW > AVG_W) ? SW : AVG_W) + 2;

  // configuration
  logic [LEN_W-1:0]  cfg_len_q;
  logic [THR_W-1:0]  cfg_thr_q;
  logic [THR_W-1:0]  cfg_mrg_q;
  logic [GAIN_W-1:0] cfg_gain_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len_q  <= HISTORY_LENGTH_RST;
      cfg_thr_q  <= DIP_THRESHOLD_RST;
      cfg_mrg_q  <= REARM_MARGIN_RST;
      cfg_gain_q <= EMA_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HISTORY_LENGTH: cfg_len_q  <= cfg_data[LEN_W-1:0];
        REG_DIP_THRESHOLD:  cfg_thr_q  <= cfg_data[THR_W-1:0];
        REG_REARM_MARGIN:   cfg_mrg_q  <= cfg_data[THR_W-1:0];
        REG_EMA_GAIN:       cfg_gain_q <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic                   op_q;
  logic [SAMPLE_BITS-1:0] smp_q;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q  <= in_opcode;
      smp_q <= in_sample;
    end
  end

  // state
  logic [AW-1:0]     wp_q;
  logic [FILL_W-1:0] held_q;
  logic [AVG_W-1:0]  avg_q;
  logic              seeded_q;
  logic              do_upd_q;

  // average update
  logic [SW-1:0]           scaled;
  logic signed [DW-1:0]    diff;
  logic signed [DW-1:0]    diff_abs;
  logic                    neg_q;
  logic [MAG_W-1:0]        mag_q;
  logic [PROD_W-1:0]       prod_q;
  logic [PROD_W-1:0]       rounded;
  logic [MAG_W-1:0]        step;
  logic signed [NX_W-1:0]  avg_nx;
  logic [AVG_W-1:0]        avg_clamped;

  assign scaled   = {smp_q, FRAC_W'(0)};
  assign diff     = $signed(DW'(scaled)) - $signed(DW'(avg_q));
  assign diff_abs = diff[DW-1] ? -diff : diff;
  assign rounded  = prod_q + PROD_W'(1 << (FRAC_W - 1));
  assign step     = rounded[PROD_W-1:FRAC_W];

  always_comb begin
    if (neg_q) begin
      avg_nx = $signed(NX_W'(avg_q)) - $signed(NX_W'(step));
    end else begin
      avg_nx = $signed(NX_W'(avg_q)) + $signed(NX_W'(step));
    end
    if (avg_nx < 0) begin
      avg_clamped = '0;
    end else if (avg_nx > $signed(NX_W'(AVG_MAX))) begin
      avg_clamped = AVG_MAX;
    end else begin
      avg_clamped = avg_nx[AVG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_hist) begin
      neg_q <= diff[DW-1];
      mag_q <= diff_abs[MAG_W-1:0];
    end
    if (cmd.mul_en) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(cfg_gain_q);
    end
  end

  // scan
  logic [NW-1:0]     len_eff;
  logic [NW-1:0]     held_ext;
  logic [NW-1:0]     n_sel;
  logic [NW-1:0]     wp_ext;
  logic [NW-1:0]     start_ext;
  logic [AW-1:0]     rd_addr_q;
  logic [FILL_W-1:0] remaining_q;
  logic              rd_valid_q;
  logic              issue;
  logic              armed_q;
  logic [DIP_W-1:0]  count_q;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [CW-1:0]     s_cmp;
  logic [CW-1:0]     avg_cmp;
  logic [CW-1:0]     thr_cmp;
  logic [CW-1:0]     mrg_cmp;
  logic              is_dip;
  logic              is_rearm;

  assign len_eff   = (cfg_len_q == '0) ? NW'(1) : NW'(cfg_len_q);
  assign held_ext  = NW'(held_q);
  assign n_sel     = (len_eff > held_ext) ? held_ext : len_eff;
  assign wp_ext    = NW'(wp_q);
  assign start_ext = (wp_ext >= n_sel) ? (wp_ext - n_sel)
                                       : (wp_ext + NW'(HISTORY_DEPTH) - n_sel);
  assign issue     = cmd.scan_en && (remaining_q != '0);

  assign s_cmp    = CW'({rdata, FRAC_W'(0)});
  assign avg_cmp  = CW'(avg_q);
  assign thr_cmp  = CW'({cfg_thr_q, FRAC_W'(0)});
  assign mrg_cmp  = CW'({cfg_mrg_q, FRAC_W'(0)});
  assign is_dip   = armed_q && (avg_cmp > s_cmp) && ((avg_cmp - s_cmp) >= thr_cmp);
  assign is_rearm = !armed_q && (s_cmp > (avg_cmp + mrg_cmp));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp_q        <= '0;
      held_q      <= '0;
      avg_q       <= '0;
      seeded_q    <= 1'b0;
      do_upd_q    <= 1'b0;
      remaining_q <= '0;
      rd_valid_q  <= 1'b0;
      armed_q     <= 1'b1;
      count_q     <= '0;
    end else begin
      rd_valid_q <= issue;
      if (cmd.write_hist) begin
        wp_q     <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
        do_upd_q <= seeded_q;
        if (held_q != FILL_W'(HISTORY_DEPTH)) begin
          held_q <= held_q + FILL_W'(1);
        end
        if (!seeded_q) begin
          avg_q    <= AVG_W'(scaled);
          seeded_q <= 1'b1;
        end
      end
      if (cmd.upd_en && do_upd_q) begin
        avg_q <= avg_clamped;
      end
      if (cmd.scan_setup) begin
        rd_addr_q   <= start_ext[AW-1:0];
        remaining_q <= seeded_q ? n_sel[FILL_W-1:0] : '0;
        armed_q     <= 1'b1;
        count_q     <= '0;
      end
      if (issue) begin
        rd_addr_q   <= (rd_addr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_addr_q + AW'(1);
        remaining_q <= remaining_q - FILL_W'(1);
      end
      if (rd_valid_q) begin
        if (is_dip) begin
          armed_q <= 1'b0;
          count_q <= count_q + DIP_W'(1);
        end else if (is_rearm) begin
          armed_q <= 1'b1;
        end
      end
    end
  end

  edc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.write_hist),
    .addr  (cmd.write_hist ? wp_q : rd_addr_q),
    .wdata (smp_q),
    .rdata (rdata)
  );

  // result register
  logic                out_valid_q;
  logic [AVG_W-1:0]    out_avg_q;
  logic                out_seeded_q;
  logic [DIP_W-1:0]    out_dips_q;
  logic [FILL_W-1:0]   out_fill_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (result.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_avg_q    <= avg_q;
      out_seeded_q <= seeded_q;
      out_dips_q   <= (op_q == OP_QUERY) ? count_q : '0;
      out_fill_q   <= held_q;
    end
  end

  assign result.valid         = out_valid_q;
  assign result.average       = out_avg_q;
  assign result.average_valid = out_seeded_q;
  assign result.dip_count     = out_dips_q;
  assign result.history_fill  = out_fill_q;

  assign status.scan_done = (remaining_q == '0) && !rd_valid_q;
  assign status.out_busy  = out_valid_q && !result.ready;

  `ASSERT_IMPL(a_held_bound, clk, rst, 1'b1, held_q <= FILL_W'(HISTORY_DEPTH), "history fill above depth")
  `ASSERT_IMPL(a_scan_bound, clk, rst, 1'b1, remaining_q <= held_q, "scan longer than held history")
  `ASSERT_NEXT(a_seed_sticky, clk, rst, seeded_q, seeded_q, "average seed lost")
  `ASSERT_IMPL(a_load_free, clk, rst, cmd.out_load, !(out_valid_q && !result.ready), "result overwritten before taken")

endmodule

`default_nettype wire

[design/ema_dip_counter_with_history.sv]
// top level: moving-average dip counter with sample history
//
//   channel   dir   handshake      payload
//   item      in    valid/ready    opcode, sample
//   result    out   valid/ready    average, average_valid, dip_count, history_fill
//   cfg       in    cfg_we         cfg_index, cfg_data
//
// a sample item passes ram write, multiply, update and load after accept before its result is valid
// a query item scans n entries, n = min(samples held, history_length, 0 read as 1), none before any sample;
// the scan reads one history entry per cycle through the single ram port
// the next item can be accepted in the cycle after the load, while a result waits in the output register
// reset (synchronous) empties the history and clears the average; no clearing pass
// a stalled result holds the block in its final step until taken
`default_nettype none

module ema_dip_counter_with_history #(
  parameter int HISTORY_DEPTH = edc_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = edc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [edc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [edc_pkg::CFG_DATA_W-1:0]  cfg_data,
  edc_in_if.sink                               item,
  edc_out_if.source                            result
);

  import edc_pkg::*;

  edc_cmd_t    cmd;
  edc_status_t status;
  logic        in_ready;

  assign item.ready = in_ready;

  edc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_opcode (item.opcode),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .status    (status)
  );

  edc_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (item.valid && in_ready),
    .in_opcode (item.opcode),
    .in_sample (item.sample),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

`default_nettype wire

[sim/ema_dip_counter_with_history_tb.sv]
// testbench for the moving-average dip counter: self-checking item and result streams
`timescale 1ns / 100ps

module ema_dip_counter_with_history_tb;
  import edc_pkg::*;

  localparam int HIST_DEPTH = HISTORY_DEPTH_DEF;
  localparam int CODE_MAX   = (1 << SAMPLE_BITS_DEF) - 1;
  localparam int FILL_W     = $clog2(HISTORY_DEPTH_DEF + 1);

  typedef struct packed {
    logic [AVG_W-1:0]  average;
    logic              average_valid;
    logic [DIP_W-1:0]  dip_count;
    logic [FILL_W-1:0] history_fill;
  } dip_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  edc_in_if  item_if ();
  edc_out_if result_if ();

  ema_dip_counter_with_history dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_if),
    .result    (result_if)
  );

  // model state
  logic [SAMPLE_BITS_DEF-1:0] sample_ring [HIST_DEPTH];
  int unsigned                ring_wr;
  int unsigned                ring_held;
  logic [AVG_W-1:0]           avg_q;
  bit                         avg_seeded;
  logic [LEN_W-1:0]           cfg_len;
  logic [THR_W-1:0]           cfg_thr;
  logic [THR_W-1:0]           cfg_margin;
  logic [GAIN_W-1:0]          cfg_gain;

  dip_result_t expected_results[$];
  int          mismatches = 0;
  bit          idle_on = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(80_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void reset_model();
    ring_wr    = 0;
    ring_held  = 0;
    avg_q      = '0;
    avg_seeded = 1'b0;
    cfg_len    = HISTORY_LENGTH_RST;
    cfg_thr    = DIP_THRESHOLD_RST;
    cfg_margin = REARM_MARGIN_RST;
    cfg_gain   = EMA_GAIN_RST;
  endfunction

  function automatic void record_sample(input logic [SAMPLE_BITS_DEF-1:0] smp);
    longint            diff;
    longint            avg_step;
    longint            next_avg;
    longint unsigned   mag;
    sample_ring[ring_wr] = smp;
    ring_wr = (ring_wr + 1) % HIST_DEPTH;
    if (ring_held < HIST_DEPTH) ring_held++;
    if (!avg_seeded) begin
      avg_q      = AVG_W'(longint'(smp) << FRAC_W);
      avg_seeded = 1'b1;
    end else begin
      diff     = (longint'(smp) << FRAC_W) - longint'(avg_q);
      mag      = longint'(diff < 0 ? -diff : diff) * longint'(cfg_gain);
      mag      = (mag + 64'h8000) >> FRAC_W;
      avg_step = diff < 0 ? -longint'(mag) : longint'(mag);
      next_avg = longint'(avg_q) + avg_step;
      if (next_avg < 0) next_avg = 0;
      if (next_avg > longint'(AVG_MAX)) next_avg = longint'(AVG_MAX);
      avg_q = next_avg[AVG_W-1:0];
    end
  endfunction

  function automatic logic [DIP_W-1:0] count_window_dips();
    int unsigned n;
    int unsigned pos;
    int unsigned dips;
    bit          armed;
    longint      code;
    longint      avg;
    longint      thr;
    longint      margin;
    if (!avg_seeded) return '0;
    n = (cfg_len == 0) ? 1 : cfg_len;
    if (n > ring_held) n = ring_held;
    pos    = (ring_wr + HIST_DEPTH - (n % HIST_DEPTH)) % HIST_DEPTH;
    dips   = 0;
    armed  = 1'b1;
    avg    = longint'(avg_q);
    thr    = longint'(cfg_thr) << FRAC_W;
    margin = longint'(cfg_margin) << FRAC_W;
    for (int unsigned i = 0; i < n; i++) begin
      code = longint'(sample_ring[pos]) << FRAC_W;
      pos  = (pos + 1) % HIST_DEPTH;
      if (armed && avg > code && avg - code >= thr) begin
        armed = 1'b0;
        dips++;
      end else if (!armed && code > avg + margin) begin
        armed = 1'b1;
      end
    end
    return dips[DIP_W-1:0];
  endfunction

  function automatic void predict_item(input logic op, input logic [SAMPLE_BITS_DEF-1:0] smp);
    dip_result_t r;
    r.dip_count = '0;
    if (op == OP_SAMPLE) record_sample(smp);
    else r.dip_count = count_window_dips();
    r.average       = avg_q;
    r.average_valid = avg_seeded;
    r.history_fill  = ring_held[FILL_W-1:0];
    expected_results.push_back(r);
  endfunction

  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sample values placed around the dip and re-arm levels, near the average, or drawn at random
  function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
    int a;
    int r;
    int v;
    a = avg_seeded ? int'(avg_q[AVG_W-1:FRAC_W]) : CODE_MAX / 2;
    r = $urandom_range(0, 99);
    if (r < 25) v = $urandom_range(0, CODE_MAX);
    else if (r < 55) v = a - int'(cfg_thr) + int'($urandom_range(0, 4)) - 2;
    else if (r < 85) v = a + int'(cfg_margin) + int'($urandom_range(0, 4)) - 2;
    else v = a + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > CODE_MAX) v = CODE_MAX;
    return v[SAMPLE_BITS_DEF-1:0];
  endfunction

  task automatic note_mismatch(input string field, input longint unsigned want,
                               input longint unsigned got);
    if (mismatches < 10)
      $display("mismatch in %s at %0t: expected %0d, got %0d", field, $time, want, got);
    mismatches++;
  endtask

  always @(negedge clk) begin
    dip_result_t got;
    dip_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got = '{average: result_if.average, average_valid: result_if.average_valid,
              dip_count: result_if.dip_count, history_fill: result_if.history_fill};
      if (expected_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result at %0t", $time);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.average !== want.average)
          note_mismatch("average", want.average, got.average);
        if (got.average_valid !== want.average_valid)
          note_mismatch("average_valid", want.average_valid, got.average_valid);
        if (got.dip_count !== want.dip_count)
          note_mismatch("dip_count", want.dip_count, got.dip_count);
        if (got.history_fill !== want.history_fill)
          note_mismatch("history_fill", want.history_fill, got.history_fill);
      end
    end
  end

  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = idle_gap();
      if (n > 0) begin
        result_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_item(input logic op, input logic [SAMPLE_BITS_DEF-1:0] smp);
    int gap;
    bit taken;
    gap = idle_gap();
    repeat (gap) begin
      item_if.valid  <= 1'b0;
      item_if.opcode <= 1'($urandom);
      item_if.sample <= SAMPLE_BITS_DEF'($urandom);
      @(posedge clk);
    end
    item_if.valid  <= 1'b1;
    item_if.opcode <= op;
    item_if.sample <= smp;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (item_if.ready) begin
        taken = 1'b1;
        predict_item(op, smp);
      end
      @(posedge clk);
    end
  endtask

  task automatic random_item(input int query_pct);
    if ($urandom_range(0, 99) < query_pct)
      send_item(OP_QUERY, SAMPLE_BITS_DEF'($urandom));
    else
      send_item(OP_SAMPLE, pick_sample());
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_HISTORY_LENGTH: cfg_len    = value[LEN_W-1:0];
      REG_DIP_THRESHOLD:  cfg_thr    = value[THR_W-1:0];
      REG_REARM_MARGIN:   cfg_margin = value[THR_W-1:0];
      REG_EMA_GAIN:       cfg_gain   = value[GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned len, input int unsigned thr,
                            input int unsigned margin, input int unsigned gain);
    write_reg(REG_HISTORY_LENGTH, len);
    write_reg(REG_DIP_THRESHOLD, thr);
    write_reg(REG_REARM_MARGIN, margin);
    write_reg(REG_EMA_GAIN, gain);
  endtask

  // query before any sample has seeded the average
  task automatic test_no_average();
    send_item(OP_QUERY, SAMPLE_BITS_DEF'(CODE_MAX));
    drain();
  endtask

  // extreme codes, zero and long history length, zero threshold, full and zero gain
  task automatic test_extremes();
    send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(CODE_MAX));
    send_item(OP_SAMPLE, '0);
    send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(2048));
    send_item(OP_QUERY, '0);
    drain();
    set_config(0, 0, 0, 65535);
    send_item(OP_SAMPLE, '0);
    send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(CODE_MAX));
    send_item(OP_QUERY, '0);
    send_item(OP_SAMPLE, '0);
    send_item(OP_QUERY, SAMPLE_BITS_DEF'(CODE_MAX));
    drain();
    set_config(2047, 4095, 4095, 0);
    send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(1234));
    send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(CODE_MAX));
    send_item(OP_QUERY, '0);
    drain();
  endtask

  // samples 1 and 5 below the seeded average, 2 above, then 1 below and equal, threshold and margin 1
  task automatic test_hysteresis();
    int a;
    set_config(5, 1, 1, 65535);
    send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(2000));
    drain();
    write_reg(REG_EMA_GAIN, 1);
    a = int'(avg_q[AVG_W-1:FRAC_W]);
    send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(a - 1));
    send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(a - 5));
    send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(a + 2));
    send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(a - 1));
    send_item(OP_SAMPLE, SAMPLE_BITS_DEF'(a));
    send_item(OP_QUERY, '0);
    drain();
  endtask

  task automatic test_random_windows();
    for (int round = 0; round < 5; round++) begin
      case (round)
        0: set_config(0, 0, 0, 65535);
        1: set_config(2047, 4095, 4095, 1);
        default: set_config($urandom_range(1, 40), $urandom_range(0, 300),
                            $urandom_range(0, 150),
                            $urandom_range(0, 1) ? $urandom_range(1, 512)
                                                 : $urandom_range(1, 65535));
      endcase
      idle_on = (round != 2);
      repeat (40) random_item(25);
      drain();
    end
    idle_on = 1'b1;
  endtask

  // fill the ring past its depth so it saturates and wraps
  task automatic test_history_wrap();
    set_config(HIST_DEPTH, 150, 40, 66);
    idle_on = 1'b0;
    for (int i = 0; i < 900; i++) begin
      if (i == 700) idle_on = 1'b1;
      random_item(2);
    end
    drain();
    write_reg(REG_HISTORY_LENGTH, 2047);
    repeat (8) random_item(50);
    drain();
    write_reg(REG_HISTORY_LENGTH, HIST_DEPTH - 1);
    repeat (8) random_item(50);
    drain();
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    item_if.valid   = 1'b0;
    item_if.opcode  = OP_SAMPLE;
    item_if.sample  = '0;
    result_if.ready = 1'b0;
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_average();
    test_extremes();
    test_hysteresis();
    test_random_windows();
    test_history_wrap();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/edc_pkg.sv
design/edc_stream_if.sv
design/edc_ram.sv
design/edc_ctrl.sv
design/edc_datapath.sv
design/ema_dip_counter_with_history.sv
sim/ema_dip_counter_with_history_tb.sv
